// ===== rtl/lsq_pkg.sv =====
package lsq_pkg;

    // Fixed sample and result geometry.
    localparam int SB          = 16;
    localparam int FRAC        = 16;
    localparam int W           = 128;
    localparam int QW          = 64;
    localparam int OUT_W       = 48;
    localparam int CHI_LSB     = 32;
    localparam int CNT_OUT_W   = 11;
    localparam int IN_DATA_W   = 2 * SB;
    localparam int OUT_PACK_W  = 5 * OUT_W + 2 * SB + CNT_OUT_W;
    localparam int OUT_DATA_W  = ((OUT_PACK_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_DATA_W - OUT_PACK_W;
    localparam int QDEPTH      = 2;

    localparam logic [QW-1:0] OUT_LIM  = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [QW-1:0] WIDE_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef logic signed [W-1:0] wide_t;

    typedef struct packed {
        logic signed [SB-1:0] y;
        logic signed [SB-1:0] x;
        logic                 store;
        logic                 last;
    } lsq_entry_t;

    typedef struct packed {
        logic                  start;
        wide_t                 a;
        logic signed [QW-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                  start;
        logic                  wide;
        wide_t                 num;
        logic [W-1:0]          den;
    } div_req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FLAT = 2'd1,
        ST_SAT  = 2'd2,
        ST_DROP = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] intercept;
        logic [OUT_W-1:0]        chi;
        logic signed [SB-1:0]    first_x;
        logic signed [SB-1:0]    final_x;
        logic signed [OUT_W-1:0] fit_first;
        logic signed [OUT_W-1:0] fit_final;
        logic [CNT_OUT_W-1:0]    count;
        status_t                 status;
    } lsq_result_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_ROUND,
        D_CLAMP
    } div_state_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SETTLE,
        S_SXX1,
        S_SXX2,
        S_SXY1,
        S_SXY2,
        S_BASE1,
        S_BASE2,
        S_PREP,
        S_SLOPE,
        S_ICPT,
        S_F0M,
        S_F0D,
        S_F1M,
        S_F1D,
        S_RDW,
        S_RESM,
        S_RESD,
        S_RESQ,
        S_RESA,
        S_EMIT
    } seq_state_t;

endpackage

// ===== rtl/lsq_front.sv =====
module lsq_front #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lsq_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                            in_last,
    output logic                            q_valid,
    input  logic                            q_pop,
    output lsq_pkg::lsq_entry_t             q_head
);
    import lsq_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int PTR_W = $clog2(QDEPTH);

    logic [CNT_W-1:0] fcnt_reg, fcnt_next;
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    lsq_entry_t       q_mem [QDEPTH];
    lsq_entry_t       entry;
    logic             push;

    // The front keeps its own per-set count, so each beat is tagged as stored or dropped.
    always_comb
    begin
        entry.x     = in_data[SB-1:0];
        entry.y     = in_data[2*SB-1:SB];
        entry.last  = in_last;
        entry.store = (fcnt_reg < CNT_W'(MAX_SAMPLES));
        push        = in_valid && in_ready;
        fcnt_next   = fcnt_reg;
        if (push)
        begin
            if (in_last)
                fcnt_next = '0;
            else if (entry.store)
                fcnt_next = fcnt_reg + 1'b1;
        end
    end

    assign in_ready = (fill_reg != (PTR_W + 1)'(QDEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_head   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fcnt_reg <= fcnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !q_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (!push && q_pop)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= entry;
    end

endmodule

// ===== rtl/lsq_mul.sv =====
module lsq_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  lsq_pkg::mul_req_t req,
    output logic              done,
    output lsq_pkg::wide_t    prod
);
    import lsq_pkg::*;

    logic [W-1:0]  acc_reg, ma_reg;
    logic [QW-1:0] mb_reg;
    logic          neg_reg, busy_reg, done_reg;
    wide_t         prod_reg;
    logic          finish;

    // Shift-add over the magnitude of b; stops as soon as no multiplier bits remain.
    assign finish = busy_reg && (mb_reg == '0);
    assign done   = done_reg;
    assign prod   = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish && !req.start;
            if (req.start)
                busy_reg <= 1'b1;
            else if (finish)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            ma_reg  <= req.a[W-1] ? -req.a : req.a;
            mb_reg  <= req.b[QW-1] ? -req.b : req.b;
            neg_reg <= req.a[W-1] ^ req.b[QW-1];
        end
        else if (busy_reg && !finish)
        begin
            if (mb_reg[0])
                acc_reg <= acc_reg + ma_reg;
            ma_reg <= ma_reg << 1;
            mb_reg <= mb_reg >> 1;
        end
        if (finish)
            prod_reg <= neg_reg ? -acc_reg : acc_reg;
    end

endmodule

// ===== rtl/lsq_div.sv =====
module lsq_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsq_pkg::div_req_t             req,
    output logic                          done,
    output logic signed [lsq_pkg::QW-1:0] quo,
    output logic                          sat
);
    import lsq_pkg::*;

    localparam int IT_W = $clog2(W);

    div_state_t        state_reg, state_next;
    logic [W-1:0]      n_reg, r_reg, q_reg, den_reg;
    logic [IT_W-1:0]   cnt_reg;
    logic              neg_reg, wide_reg, done_reg, sat_reg;
    logic signed [QW-1:0] quo_reg;
    logic [W-1:0]      trial;
    logic              ge;
    logic [QW-1:0]     lmag, qc;
    logic              over;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (req.start) state_next = D_RUN;
            D_RUN:   if (cnt_reg == '0) state_next = D_ROUND;
            D_ROUND: state_next = D_CLAMP;
            D_CLAMP: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    // Restoring division, one quotient bit a cycle; then round half away and clamp.
    always_comb
    begin
        trial = {r_reg[W-2:0], n_reg[W-1]};
        ge    = (trial >= den_reg);
        lmag  = (wide_reg ? WIDE_LIM : OUT_LIM) + QW'(neg_reg);
        over  = (q_reg[W-1:QW] != '0) || (q_reg[QW-1:0] > lmag);
        qc    = over ? lmag : q_reg[QW-1:0];
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign sat  = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_CLAMP);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    n_reg    <= req.num[W-1] ? -req.num : req.num;
                    neg_reg  <= req.num[W-1];
                    wide_reg <= req.wide;
                    den_reg  <= req.den;
                    r_reg    <= '0;
                    q_reg    <= '0;
                    cnt_reg  <= '1;
                end
            end
            D_RUN:
            begin
                n_reg   <= n_reg << 1;
                r_reg   <= ge ? trial - den_reg : trial;
                q_reg   <= {q_reg[W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            D_ROUND:
            begin
                if ({r_reg[W-2:0], 1'b0} >= den_reg)
                    q_reg <= q_reg + 1'b1;
            end
            D_CLAMP:
            begin
                quo_reg <= neg_reg ? -qc : qc;
                sat_reg <= over;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/lsq_back.sv =====
module lsq_back #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  lsq_pkg::lsq_entry_t            q_head,
    output lsq_pkg::mul_req_t              mul_req,
    input  logic                           mul_done,
    input  lsq_pkg::wide_t                 mul_prod,
    output lsq_pkg::div_req_t              div_req,
    input  logic                           div_done,
    input  logic signed [lsq_pkg::QW-1:0]  div_quo,
    input  logic                           div_sat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lsq_pkg::lsq_result_t           result
);
    import lsq_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SB + CNT_W;
    localparam int SQ_W   = 2 * SB + CNT_W;

    seq_state_t state_reg, state_next;
    logic       issued_reg, issued_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic signed [SQ_W-1:0]  sum_xx_reg, sum_xy_reg;
    logic signed [SB-1:0]    px_reg, py_reg, first_x_reg, last_x_reg;
    logic signed [2*SB-1:0]  pxx_reg, pxy_reg;
    logic pend_reg, ovf_reg, out_valid_reg, flat_reg, sat_reg;
    wide_t t1_reg, sxx_reg, sxy_reg, base_reg, tilt_reg;
    logic [W-1:0] den_reg, acc_reg;
    logic signed [OUT_W-1:0] slope_reg, icpt_reg, f0_reg, f1_reg;
    logic signed [QW-1:0] r_reg;
    logic [2*SB-1:0] rd_reg;
    logic [2*SB-1:0] sample_mem [MAX_SAMPLES];
    lsq_result_t res_reg;

    logic uses_mul, uses_div, unit_done, unit_go, step_done, emit_ok, last_idx;
    logic signed [SB-1:0] rd_x, rd_y;
    logic signed [QW-1:0] y_q;
    wide_t line_num;
    logic [W:0] acc_sum;
    logic chi_over;
    status_t status;

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        q_pop       = 1'b0;
        unit_go     = 1'b0;
        step_done   = 1'b0;
        uses_mul    = state_reg inside {S_SXX1, S_SXX2, S_SXY1, S_SXY2, S_BASE1, S_BASE2,
                                        S_F0M, S_F1M, S_RESM, S_RESQ};
        uses_div    = state_reg inside {S_SLOPE, S_ICPT, S_F0D, S_F1D, S_RESD};
        unit_done   = uses_mul ? mul_done : div_done;
        emit_ok     = !out_valid_reg || out_ready;
        last_idx    = (idx_reg == ADDR_W'(cnt_reg - 1'b1));
        if (uses_mul || uses_div)
        begin
            if (!issued_reg)
            begin
                unit_go     = 1'b1;
                issued_next = 1'b1;
            end
            else if (unit_done)
            begin
                issued_next = 1'b0;
                step_done   = 1'b1;
            end
        end
        case (state_reg)
            S_LOAD:
            begin
                q_pop = q_valid;
                if (q_valid && q_head.last)
                    state_next = S_SETTLE;
            end
            S_SETTLE: state_next = S_SXX1;
            S_SXX1:   if (step_done) state_next = S_SXX2;
            S_SXX2:   if (step_done) state_next = S_SXY1;
            S_SXY1:   if (step_done) state_next = S_SXY2;
            S_SXY2:   if (step_done) state_next = S_BASE1;
            S_BASE1:  if (step_done) state_next = S_BASE2;
            S_BASE2:  if (step_done) state_next = S_PREP;
            S_PREP:   state_next = S_SLOPE;
            S_SLOPE:  if (step_done) state_next = S_ICPT;
            S_ICPT:   if (step_done) state_next = S_F0M;
            S_F0M:    if (step_done) state_next = S_F0D;
            S_F0D:    if (step_done) state_next = S_F1M;
            S_F1M:    if (step_done) state_next = S_F1D;
            S_F1D:    if (step_done) state_next = S_RDW;
            S_RDW:    state_next = S_RESM;
            S_RESM:   if (step_done) state_next = S_RESD;
            S_RESD:   if (step_done) state_next = S_RESQ;
            S_RESQ:   if (step_done) state_next = S_RESA;
            S_RESA:   state_next = last_idx ? S_EMIT : S_RDW;
            S_EMIT:   if (emit_ok) state_next = S_LOAD;
            default:  state_next = S_LOAD;
        endcase
    end

    // Operand selection for the shared multiplier and divider, and the fit status.
    always_comb
    begin
        rd_x     = rd_reg[SB-1:0];
        rd_y     = rd_reg[2*SB-1:SB];
        y_q      = QW'(rd_y) <<< FRAC;
        line_num = (base_reg + t1_reg) <<< FRAC;
        acc_sum  = {1'b0, acc_reg} + {1'b0, t1_reg};
        chi_over = (acc_reg[W-1:CHI_LSB+OUT_W] != '0);

        mul_req.start = unit_go && uses_mul;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (state_reg)
            S_SXX1:  begin mul_req.a = W'(sum_xx_reg); mul_req.b = QW'(cnt_reg);   end
            S_SXX2:  begin mul_req.a = W'(sum_x_reg);  mul_req.b = QW'(sum_x_reg); end
            S_SXY1:  begin mul_req.a = W'(sum_xy_reg); mul_req.b = QW'(cnt_reg);   end
            S_SXY2:  begin mul_req.a = W'(sum_x_reg);  mul_req.b = QW'(sum_y_reg); end
            S_BASE1: begin mul_req.a = W'(sum_xx_reg); mul_req.b = QW'(sum_y_reg); end
            S_BASE2: begin mul_req.a = W'(sum_x_reg);  mul_req.b = QW'(sum_xy_reg); end
            S_F0M:   begin mul_req.a = tilt_reg;       mul_req.b = QW'(first_x_reg); end
            S_F1M:   begin mul_req.a = tilt_reg;       mul_req.b = QW'(last_x_reg);  end
            S_RESM:  begin mul_req.a = tilt_reg;       mul_req.b = QW'(rd_x);        end
            S_RESQ:  begin mul_req.a = W'(r_reg);      mul_req.b = r_reg;            end
            default: ;
        endcase

        div_req.start = unit_go && uses_div;
        div_req.wide  = (state_reg == S_RESD);
        div_req.den   = den_reg;
        case (state_reg)
            S_SLOPE: div_req.num = tilt_reg <<< FRAC;
            S_ICPT:  div_req.num = base_reg <<< FRAC;
            default: div_req.num = line_num;
        endcase

        if (ovf_reg)
            status = ST_DROP;
        else if (flat_reg && (cnt_reg > CNT_W'(1)))
            status = ST_FLAT;
        else if (sat_reg || chi_over)
            status = ST_SAT;
        else
            status = ST_OK;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            issued_reg    <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_xy_reg    <= '0;
            pend_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            pend_reg   <= q_pop && q_head.store;
            if (q_pop)
            begin
                if (q_head.store)
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (state_reg == S_EMIT && emit_ok)
            begin
                cnt_reg       <= '0;
                ovf_reg       <= 1'b0;
                sum_x_reg     <= '0;
                sum_y_reg     <= '0;
                sum_xx_reg    <= '0;
                sum_xy_reg    <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (out_ready)
                    out_valid_reg <= 1'b0;
                if (pend_reg)
                begin
                    sum_x_reg  <= sum_x_reg + SUM_W'(px_reg);
                    sum_y_reg  <= sum_y_reg + SUM_W'(py_reg);
                    sum_xx_reg <= sum_xx_reg + SQ_W'(pxx_reg);
                    sum_xy_reg <= sum_xy_reg + SQ_W'(pxy_reg);
                end
            end
            if (state_reg == S_F1D && step_done)
                idx_reg <= '0;
            else if (state_reg == S_RESA && !last_idx)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            px_reg  <= q_head.x;
            py_reg  <= q_head.y;
            pxx_reg <= q_head.x * q_head.x;
            pxy_reg <= q_head.x * q_head.y;
            if (q_head.store)
            begin
                sample_mem[cnt_reg[ADDR_W-1:0]] <= {q_head.y, q_head.x};
                last_x_reg <= q_head.x;
                if (cnt_reg == '0)
                    first_x_reg <= q_head.x;
            end
        end
        rd_reg <= sample_mem[idx_reg];

        case (state_reg)
            S_SETTLE: sat_reg <= 1'b0;
            S_SXX1, S_SXY1, S_BASE1, S_F0M, S_F1M, S_RESM, S_RESQ:
            begin
                if (step_done)
                    t1_reg <= mul_prod;
            end
            S_SXX2:  if (step_done) sxx_reg  <= t1_reg - mul_prod;
            S_SXY2:  if (step_done) sxy_reg  <= t1_reg - mul_prod;
            S_BASE2: if (step_done) base_reg <= t1_reg - mul_prod;
            S_PREP:
            begin
                // All x equal: the line is flat at the mean of y.
                flat_reg <= (sxx_reg == '0);
                den_reg  <= (sxx_reg == '0) ? W'(cnt_reg) : sxx_reg;
                tilt_reg <= (sxx_reg == '0) ? '0 : sxy_reg;
                if (sxx_reg == '0)
                    base_reg <= W'(sum_y_reg);
            end
            S_SLOPE:
            begin
                if (step_done)
                begin
                    slope_reg <= div_quo[OUT_W-1:0];
                    sat_reg   <= sat_reg | div_sat;
                end
            end
            S_ICPT:
            begin
                if (step_done)
                begin
                    icpt_reg <= div_quo[OUT_W-1:0];
                    sat_reg  <= sat_reg | div_sat;
                end
            end
            S_F0D:
            begin
                if (step_done)
                begin
                    f0_reg  <= div_quo[OUT_W-1:0];
                    sat_reg <= sat_reg | div_sat;
                end
            end
            S_F1D:
            begin
                if (step_done)
                begin
                    f1_reg  <= div_quo[OUT_W-1:0];
                    sat_reg <= sat_reg | div_sat;
                    acc_reg <= '0;
                end
            end
            S_RESD:  if (step_done) r_reg <= y_q - div_quo;
            S_RESA:  acc_reg <= acc_sum[W] ? '1 : acc_sum[W-1:0];
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    res_reg.slope     <= slope_reg;
                    res_reg.intercept <= icpt_reg;
                    res_reg.chi       <= chi_over ? '1 : acc_reg[CHI_LSB+OUT_W-1:CHI_LSB];
                    res_reg.first_x   <= first_x_reg;
                    res_reg.final_x   <= last_x_reg;
                    res_reg.fit_first <= f0_reg;
                    res_reg.fit_final <= f1_reg;
                    res_reg.count     <= CNT_OUT_W'(cnt_reg);
                    res_reg.status    <= status;
                end
            end
            default: ;
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (issued_reg && uses_mul))
        else $error("multiplier finished with no operation outstanding");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (issued_reg && uses_div))
        else $error("divider finished with no operation outstanding");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && emit_ok) |=> (out_valid_reg && state_reg == S_LOAD))
        else $error("result not presented after emit");

endmodule

// ===== rtl/least_squares_line_fit_top.sv =====
// Operation: a set of n samples loads at one beat per cycle; after the last beat the
// sequencer computes the sums, slope, intercept and endpoints, then runs the residual
// pass over every stored sample.
// Throughput: one sample beat per cycle while loading; the fit is bounded by the bit-serial
// divider and the shift-add multiplier, both shared.
// Reset: rst_n is asynchronous and active low; it clears all control state and the sums.
// The sample memory is not cleared; entries are always written before they are read.
//
// Structure: a front stage takes sample beats, tags each one as stored or dropped against
// the set capacity, and pushes it into a two-entry queue. The back sequencer pops the
// queue, writes the sample memory and updates the running sums of x, y, x*x and x*y.
// When the last beat of a set arrives it drives the shared multiplier and divider
// through the fit and the residual pass, then parks the result in an output register
// so the front can keep taking the next set while the result waits to be taken.
module least_squares_line_fit_top #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_sample [15:0], y_sample [31:16]
    input  logic [lsq_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slope [47:0], intercept [95:48], chi_square [143:96], first_x [159:144],
    // final_x [175:160], fit_at_first [223:176], fit_at_final [271:224],
    // sample_count [282:272], zero fill above
    output logic [lsq_pkg::OUT_DATA_W-1:0]  m_tdata,
    // fit_status [1:0]
    output logic [1:0]                      m_tuser
);
    import lsq_pkg::*;

    logic        q_valid, q_pop;
    lsq_entry_t  q_head;
    mul_req_t    mul_req;
    logic        mul_done;
    wide_t       mul_prod;
    div_req_t    div_req;
    logic        div_done, div_sat;
    logic signed [QW-1:0] div_quo;
    lsq_result_t result;

    lsq_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    lsq_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    lsq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo),
        .sat   (div_sat)
    );

    lsq_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .mul_req   (mul_req),
        .mul_done  (mul_done),
        .mul_prod  (mul_prod),
        .div_req   (div_req),
        .div_done  (div_done),
        .div_quo   (div_quo),
        .div_sat   (div_sat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // Result beat, first field in the lowest bits.
    assign m_tdata = {PAD_W'(0), result.count, result.fit_final, result.fit_first,
                      result.final_x, result.first_x, result.chi, result.intercept,
                      result.slope};
    assign m_tuser = result.status;

endmodule
